// ----- hw/rtl/ills_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed linked list store package
// Operation codes and the record type shared by the list store.
// ----------------------------------------------------------------------------
package ills_pkg;

	localparam int WORDS  = 9;
	localparam int WORD_W = 32;

	localparam logic [1:0] FUNC_SEL   = 2'd0;
	localparam logic [1:0] FUNC_INS   = 2'd1;
	localparam logic [1:0] FUNC_DEL   = 2'd2;
	localparam logic [1:0] FUNC_CLEAR = 2'd3;

	typedef logic [WORDS-1:0][WORD_W-1:0] rec_t;

endpackage

// ----- hw/rtl/indexed_linked_list_store_core.sv -----
// ----------------------------------------------------------------------------
// Indexed linked list store core
// Ordered list of nine-word records addressed by 1-based position, kept in a
// bounded node pool with next links and a free chain.
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload
//  command   start / busy     func, position, start_x .. turn_z
//  result    done (strobe)    ok, got_start_x .. got_turn_z, length, is_empty
//
// A transaction is taken when start is high and busy is low; busy stays high
// through the cycle of its result strobe. The result strobe is high for
// exactly one cycle and the receiver cannot stall it. The walk follows one link
// a cycle; select then reads the record, insert takes a node from the free
// chain and splices it in, delete unlinks its node and returns it to the free
// chain, and clear and a failed operation go from the check to the strobe.
// After reset the block is ready at once, with no clearing pass.

module indexed_linked_list_store_core #(
	parameter int CAPACITY = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  position,
	input  logic [31:0] start_x,
	input  logic [31:0] start_y,
	input  logic [31:0] start_z,
	input  logic [31:0] move_x,
	input  logic [31:0] move_y,
	input  logic [31:0] move_z,
	input  logic [31:0] turn_x,
	input  logic [31:0] turn_y,
	input  logic [31:0] turn_z,
	output logic        done,
	output logic        ok,
	output logic [31:0] got_start_x,
	output logic [31:0] got_start_y,
	output logic [31:0] got_start_z,
	output logic [31:0] got_move_x,
	output logic [31:0] got_move_y,
	output logic [31:0] got_move_z,
	output logic [31:0] got_turn_x,
	output logic [31:0] got_turn_y,
	output logic [31:0] got_turn_z,
	output logic [7:0]  length,
	output logic        is_empty
);

	localparam int NW = $clog2(CAPACITY);
	localparam logic [7:0] CAP8 = 8'(CAPACITY);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_WALK  = 4'd2;
	localparam logic [3:0] S_SEL   = 4'd3;
	localparam logic [3:0] S_INS0  = 4'd4;
	localparam logic [3:0] S_INS1  = 4'd5;
	localparam logic [3:0] S_INS2  = 4'd6;
	localparam logic [3:0] S_INS3  = 4'd7;
	localparam logic [3:0] S_INS4  = 4'd8;
	localparam logic [3:0] S_DEL0  = 4'd9;
	localparam logic [3:0] S_DEL0W = 4'd10;
	localparam logic [3:0] S_DEL1  = 4'd11;
	localparam logic [3:0] S_DEL2  = 4'd12;
	localparam logic [3:0] S_DEL3  = 4'd13;
	localparam logic [3:0] S_DONE  = 4'd14;

	logic [3:0]         state_q;
	logic [1:0]         func_q;
	logic [7:0]         pos_q;
	ills_pkg::rec_t     data_q;
	logic [NW-1:0]      head_q;
	logic [NW-1:0]      free_q;
	logic [7:0]         count_q;
	logic [NW-1:0]      cur_q;
	logic [NW-1:0]      nn_q;
	logic [NW-1:0]      victim_q;
	logic [7:0]         steps_q;
	logic               pend_q;
	logic               ok_q;
	logic               sel_q;

	logic [NW-1:0]      lmem [CAPACITY];
	logic [CAPACITY-1:0] lvalid_q;
	logic [NW-1:0]      lmem_rd_q;
	logic               lvld_rd_q;
	logic [NW-1:0]      laddr_rd_q;
	ills_pkg::rec_t     rmem [CAPACITY];
	ills_pkg::rec_t     rec_rd_q;

	logic [NW-1:0]      link_rd;
	logic [NW-1:0]      node;
	logic [NW-1:0]      lr_addr;
	logic               lw_en;
	logic [NW-1:0]      lw_addr;
	logic [NW-1:0]      lw_data;
	logic               op_ok;
	logic [8:0]         count_p1;

	function automatic logic [NW-1:0] dflt_link(input logic [NW-1:0] a);
		logic [NW:0] s;
		s = {1'b0, a} + (NW+1)'(1);
		return (s < (NW+1)'(CAPACITY)) ? s[NW-1:0] : '0;
	endfunction

	assign link_rd  = lvld_rd_q ? lmem_rd_q : dflt_link(laddr_rd_q);
	assign node     = pend_q ? link_rd : cur_q;
	assign count_p1 = {1'b0, count_q} + 9'd1;

	always_comb begin
		unique case (func_q)
			ills_pkg::FUNC_SEL: op_ok = (pos_q != 8'd0) && (pos_q <= count_q);
			ills_pkg::FUNC_INS: op_ok = (pos_q != 8'd0) && ({1'b0, pos_q} <= count_p1)
				&& (count_q < CAP8);
			ills_pkg::FUNC_DEL: op_ok = (pos_q != 8'd0) && (pos_q <= count_q);
			default:            op_ok = 1'b1;
		endcase
	end

	always_comb begin
		lr_addr = cur_q;
		lw_en   = 1'b0;
		lw_addr = cur_q;
		lw_data = nn_q;
		case (state_q)
			S_WALK:  lr_addr = node;
			S_INS0:  lr_addr = free_q;
			S_DEL1:  lr_addr = victim_q;
			S_INS1: begin
				lw_en   = (pos_q == 8'd1);
				lw_addr = nn_q;
				lw_data = head_q;
			end
			S_INS3: begin
				lw_en   = 1'b1;
				lw_addr = nn_q;
				lw_data = link_rd;
			end
			S_INS4: begin
				lw_en   = 1'b1;
				lw_addr = cur_q;
				lw_data = nn_q;
			end
			S_DEL2: begin
				lw_en   = (pos_q != 8'd1);
				lw_addr = cur_q;
				lw_data = link_rd;
			end
			S_DEL3: begin
				lw_en   = 1'b1;
				lw_addr = victim_q;
				lw_data = free_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (lw_en) begin
			lmem[lw_addr] <= lw_data;
		end
		lmem_rd_q  <= lmem[lr_addr];
		laddr_rd_q <= lr_addr;
		if (state_q == S_INS1) begin
			rmem[nn_q] <= data_q;
		end
		if (state_q == S_SEL) begin
			rec_rd_q <= rmem[cur_q];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			func_q    <= func;
			pos_q     <= position;
			data_q[0] <= start_x;
			data_q[1] <= start_y;
			data_q[2] <= start_z;
			data_q[3] <= move_x;
			data_q[4] <= move_y;
			data_q[5] <= move_z;
			data_q[6] <= turn_x;
			data_q[7] <= turn_y;
			data_q[8] <= turn_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			free_q    <= '0;
			count_q   <= '0;
			lvalid_q  <= '0;
			lvld_rd_q <= 1'b0;
			cur_q     <= '0;
			nn_q      <= '0;
			victim_q  <= '0;
			steps_q   <= '0;
			pend_q    <= 1'b0;
			ok_q      <= 1'b0;
			sel_q     <= 1'b0;
		end else begin
			lvld_rd_q <= lvalid_q[lr_addr];
			if (lw_en) begin
				lvalid_q[lw_addr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					ok_q   <= op_ok;
					sel_q  <= op_ok && (func_q == ills_pkg::FUNC_SEL);
					cur_q  <= head_q;
					pend_q <= 1'b0;
					if (!op_ok) begin
						state_q <= S_DONE;
					end else begin
						case (func_q)
							ills_pkg::FUNC_SEL: begin
								steps_q <= pos_q - 8'd1;
								state_q <= S_WALK;
							end
							ills_pkg::FUNC_INS: begin
								steps_q <= pos_q - 8'd2;
								state_q <= S_INS0;
							end
							ills_pkg::FUNC_DEL: begin
								steps_q  <= pos_q - 8'd2;
								victim_q <= head_q;
								state_q  <= (pos_q == 8'd1) ? S_DEL1 : S_WALK;
							end
							default: begin
								lvalid_q <= '0;
								head_q   <= '0;
								free_q   <= '0;
								count_q  <= '0;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_WALK: begin
					if (steps_q == 8'd0) begin
						cur_q  <= node;
						pend_q <= 1'b0;
						case (func_q)
							ills_pkg::FUNC_SEL: state_q <= S_SEL;
							ills_pkg::FUNC_INS: state_q <= S_INS2;
							default:            state_q <= S_DEL0;
						endcase
					end else begin
						steps_q <= steps_q - 8'd1;
						pend_q  <= 1'b1;
					end
				end
				S_SEL: state_q <= S_DONE;
				S_INS0: begin
					nn_q    <= free_q;
					state_q <= S_INS1;
				end
				S_INS1: begin
					free_q <= link_rd;
					if (pos_q == 8'd1) begin
						head_q  <= nn_q;
						count_q <= count_q + 8'd1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_INS2: state_q <= S_INS3;
				S_INS3: state_q <= S_INS4;
				S_INS4: begin
					count_q <= count_q + 8'd1;
					state_q <= S_DONE;
				end
				S_DEL0: state_q <= S_DEL0W;
				S_DEL0W: begin
					victim_q <= link_rd;
					state_q  <= S_DEL1;
				end
				S_DEL1: state_q <= S_DEL2;
				S_DEL2: begin
					if (pos_q == 8'd1) begin
						head_q <= link_rd;
					end
					state_q <= S_DEL3;
				end
				S_DEL3: begin
					free_q  <= victim_q;
					count_q <= count_q - 8'd1;
					state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = (state_q == S_DONE);
	assign ok          = ok_q;
	assign got_start_x = sel_q ? rec_rd_q[0] : 32'd0;
	assign got_start_y = sel_q ? rec_rd_q[1] : 32'd0;
	assign got_start_z = sel_q ? rec_rd_q[2] : 32'd0;
	assign got_move_x  = sel_q ? rec_rd_q[3] : 32'd0;
	assign got_move_y  = sel_q ? rec_rd_q[4] : 32'd0;
	assign got_move_z  = sel_q ? rec_rd_q[5] : 32'd0;
	assign got_turn_x  = sel_q ? rec_rd_q[6] : 32'd0;
	assign got_turn_y  = sel_q ? rec_rd_q[7] : 32'd0;
	assign got_turn_z  = sel_q ? rec_rd_q[8] : 32'd0;
	assign length      = count_q;
	assign is_empty    = (count_q == 8'd0);

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("Result strobe lasted more than one cycle.");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP8) else $error("List length exceeds the pool size.");
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done)) else $error("Transaction ended without a result.");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (got_start_x == 32'd0 && got_turn_z == 32'd0))
		else $error("Failed transaction returned record data.");
`endif

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed linked list store core testbench
// Drives select, insert, delete and clear commands in bursts and checks every
// result against a behavioral list model kept beside the block.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CAP = 128;

	typedef struct {
		logic [1:0]     fn;
		logic [7:0]     pos;
		ills_pkg::rec_t rec;
		logic           chk;
		logic           x_ok;
		logic [7:0]     x_len;
	} cmd_t;

	typedef struct {
		logic           ok;
		ills_pkg::rec_t rec;
		logic [7:0]     len;
		logic           emp;
	} res_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	logic           busy;
	logic [1:0]     func = ills_pkg::FUNC_SEL;
	logic [7:0]     position = '0;
	ills_pkg::rec_t rec_in = '0;
	logic           done, ok, is_empty;
	logic [7:0]     length;
	ills_pkg::rec_t rec_out;

	ills_pkg::rec_t list_recs[$];
	res_t           pending[$];
	int             errors = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	indexed_linked_list_store_core #(.CAPACITY(CAP)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .position(position),
		.start_x(rec_in[0]), .start_y(rec_in[1]), .start_z(rec_in[2]),
		.move_x(rec_in[3]), .move_y(rec_in[4]), .move_z(rec_in[5]),
		.turn_x(rec_in[6]), .turn_y(rec_in[7]), .turn_z(rec_in[8]),
		.done(done), .ok(ok),
		.got_start_x(rec_out[0]), .got_start_y(rec_out[1]), .got_start_z(rec_out[2]),
		.got_move_x(rec_out[3]), .got_move_y(rec_out[4]), .got_move_z(rec_out[5]),
		.got_turn_x(rec_out[6]), .got_turn_y(rec_out[7]), .got_turn_z(rec_out[8]),
		.length(length), .is_empty(is_empty)
	);

	function automatic res_t apply_list_op(logic [1:0] fn, logic [7:0] pos,
		ills_pkg::rec_t rec);
		res_t r;
		int   n;
		r = '{ok: 1'b0, rec: '0, len: '0, emp: 1'b0};
		n = list_recs.size();
		case (fn)
			ills_pkg::FUNC_SEL: begin
				if (pos >= 1 && pos <= n) begin
					r.ok = 1'b1;
					r.rec = list_recs[pos-1];
				end
			end
			ills_pkg::FUNC_INS: begin
				if (pos >= 1 && pos <= n + 1 && n < CAP) begin
					r.ok = 1'b1;
					list_recs.insert(pos - 1, rec);
				end
			end
			ills_pkg::FUNC_DEL: begin
				if (pos >= 1 && pos <= n) begin
					r.ok = 1'b1;
					list_recs.delete(pos - 1);
				end
			end
			default: begin
				r.ok = 1'b1;
				list_recs.delete();
			end
		endcase
		r.len = 8'(list_recs.size());
		r.emp = (list_recs.size() == 0);
		return r;
	endfunction

	function automatic ills_pkg::rec_t rand_rec();
		ills_pkg::rec_t r;
		for (int k = 0; k < ills_pkg::WORDS; k++) begin
			case ($urandom_range(0, 5))
				0: r[k] = '0;
				1: r[k] = '1;
				default: r[k] = $urandom;
			endcase
		end
		return r;
	endfunction

	task automatic issue(cmd_t c);
		res_t r;
		@(posedge clk);
		while (busy) @(posedge clk);
		start <= 1'b1;
		func <= c.fn;
		position <= c.pos;
		rec_in <= c.rec;
		r = apply_list_op(c.fn, c.pos, c.rec);
		if (c.chk && (r.ok !== c.x_ok || r.len !== c.x_len)) begin
			$display("%0t table row mismatch: expected ok=%0d len=%0d, model ok=%0d len=%0d",
				$time, c.x_ok, c.x_len, r.ok, r.len);
			errors++;
		end
		pending.push_back(r);
		@(posedge clk);
		while (busy) @(posedge clk);
		start <= 1'b0;
	endtask

	always @(posedge clk) begin
		res_t e;
		if (done) begin
			if (pending.size() == 0) begin
				$display("%0t unexpected result transaction", $time);
				errors++;
			end else begin
				e = pending.pop_front();
				if (ok !== e.ok || rec_out !== e.rec || length !== e.len ||
					is_empty !== e.emp) begin
					$display("%0t mismatch: expected ok=%0d len=%0d empty=%0d rec=%h",
						$time, e.ok, e.len, e.emp, e.rec);
					$display("%0t          actual   ok=%0d len=%0d empty=%0d rec=%h",
						$time, ok, length, is_empty, rec_out);
					errors++;
				end
			end
		end
	end

	initial begin
		#50_000_000;
		$display("indexed_linked_list_store_core regression: fail");
		$finish;
	end

	initial begin
		cmd_t tbl[$];
		cmd_t c;
		int   n, burst, dice;
		tbl = '{
			'{ills_pkg::FUNC_SEL,   8'd1,   '0, 1'b1, 1'b0, 8'd0},
			'{ills_pkg::FUNC_DEL,   8'd1,   '0, 1'b1, 1'b0, 8'd0},
			'{ills_pkg::FUNC_INS,   8'd0,   '1, 1'b1, 1'b0, 8'd0},
			'{ills_pkg::FUNC_INS,   8'd2,   '1, 1'b1, 1'b0, 8'd0},
			'{ills_pkg::FUNC_INS,   8'd1,   '1, 1'b1, 1'b1, 8'd1},
			'{ills_pkg::FUNC_INS,   8'd1,   '0, 1'b1, 1'b1, 8'd2},
			'{ills_pkg::FUNC_INS,   8'd3,   {9{32'hA5A5_5A5A}}, 1'b1, 1'b1, 8'd3},
			'{ills_pkg::FUNC_INS,   8'd2,   {9{32'h8000_0001}}, 1'b0, 1'b0, 8'd0},
			'{ills_pkg::FUNC_SEL,   8'd1,   '0, 1'b0, 1'b0, 8'd0},
			'{ills_pkg::FUNC_SEL,   8'd2,   '0, 1'b0, 1'b0, 8'd0},
			'{ills_pkg::FUNC_SEL,   8'd4,   '0, 1'b0, 1'b0, 8'd0},
			'{ills_pkg::FUNC_SEL,   8'd5,   '0, 1'b1, 1'b0, 8'd4},
			'{ills_pkg::FUNC_SEL,   8'd0,   '0, 1'b1, 1'b0, 8'd4},
			'{ills_pkg::FUNC_SEL,   8'd255, '1, 1'b1, 1'b0, 8'd4},
			'{ills_pkg::FUNC_DEL,   8'd0,   '0, 1'b1, 1'b0, 8'd4},
			'{ills_pkg::FUNC_DEL,   8'd5,   '0, 1'b1, 1'b0, 8'd4},
			'{ills_pkg::FUNC_DEL,   8'd4,   '0, 1'b1, 1'b1, 8'd3},
			'{ills_pkg::FUNC_DEL,   8'd2,   '0, 1'b1, 1'b1, 8'd2},
			'{ills_pkg::FUNC_SEL,   8'd2,   '0, 1'b0, 1'b0, 8'd0},
			'{ills_pkg::FUNC_DEL,   8'd1,   '0, 1'b1, 1'b1, 8'd1},
			'{ills_pkg::FUNC_CLEAR, 8'd9,   '1, 1'b1, 1'b1, 8'd0},
			'{ills_pkg::FUNC_SEL,   8'd1,   '0, 1'b1, 1'b0, 8'd0}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (tbl[i]) issue(tbl[i]);

		// Fill the pool to capacity, then probe the full list at both ends.
		for (int i = 0; i < CAP; i++) begin
			c = '{ills_pkg::FUNC_INS, 8'($urandom_range(1, i + 1)), rand_rec(),
				1'b0, 1'b0, 8'd0};
			issue(c);
		end
		issue('{ills_pkg::FUNC_INS, 8'd1, rand_rec(), 1'b1, 1'b0, 8'(CAP)});
		issue('{ills_pkg::FUNC_SEL, 8'(CAP), '0, 1'b0, 1'b0, 8'd0});
		issue('{ills_pkg::FUNC_DEL, 8'(CAP), '0, 1'b0, 1'b0, 8'd0});
		issue('{ills_pkg::FUNC_INS, 8'(CAP), rand_rec(), 1'b0, 1'b0, 8'd0});
		issue('{ills_pkg::FUNC_CLEAR, 8'd0, '0, 1'b0, 1'b0, 8'd0});

		n = 0;
		while (n < 250) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst; b++) begin
				dice = $urandom_range(0, 99);
				c.rec = rand_rec();
				c.chk = 1'b0;
				c.x_ok = 1'b0;
				c.x_len = '0;
				if (dice < 40) c.fn = ills_pkg::FUNC_INS;
				else if (dice < 70) c.fn = ills_pkg::FUNC_SEL;
				else if (dice < 97) c.fn = ills_pkg::FUNC_DEL;
				else c.fn = ills_pkg::FUNC_CLEAR;
				if ($urandom_range(0, 9) == 0) c.pos = 8'($urandom);
				else c.pos = 8'($urandom_range(1, list_recs.size() + 1));
				issue(c);
				n++;
			end
			if ($urandom_range(0, 15) == 0) begin
				while (pending.size() != 0) @(posedge clk);
			end else begin
				repeat ($urandom_range(0, 20)) @(posedge clk);
			end
		end

		while (pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending.size() == 0)
			$display("indexed_linked_list_store_core regression: pass");
		else
			$display("indexed_linked_list_store_core regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/ills_pkg.sv
hw/rtl/indexed_linked_list_store_core.sv
bench/tb_top.sv
